FILE: hdl/rkoc_pkg.sv
// shared types and constants for the record key order checker
package rkoc_pkg;

  localparam int KEY_BYTES_DEF = 256;

  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int INDEX_W = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_KEY_BEGIN    = 2'd1,
    REG_KEY_END      = 2'd2,
    REG_DESCENDING   = 2'd3
  } cfg_reg_t;

  // outcome of the running key comparison within one record
  typedef enum logic [1:0] {
    CMP_NONE    = 2'd0,
    CMP_GREATER = 2'd1,
    CMP_SMALLER = 2'd2
  } cmp_outcome_t;

endpackage

FILE: hdl/record_key_order_checker.sv
// top level of the record key order checker
//
//  channel  | dir | handshake                  | contents
//  ---------+-----+----------------------------+------------------------------------
//  s_axis   | in  | tvalid / tready            | one record stream byte per transfer
//  m_axis   | out | tvalid / tready            | index, in-order and sticky violation
//  cfg      | in  | cfg_we, no back-pressure   | block_length, key_begin, key_end, descending
//
// a byte per cycle unless stalled; a result goes via the compare stage and output register
// the key store is a read-first memory: the old key byte is read while the new one is written
// the compare stage holds only when a result is due and the output register is still full
// rst clears the position, the comparison state, the record count and the sticky flag;
// the key store is not cleared, the first record after reset is never compared
module record_key_order_checker #(
  parameter int KEY_BYTES = rkoc_pkg::KEY_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rkoc_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] data_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rkoc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [39:0] record_index,
                                                            // [40] in_order,
                                                            // [41] any_violation, [47:42] zero
  input  logic                              cfg_we,
  input  logic [rkoc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rkoc_pkg::CFG_W-1:0]        cfg_data
);

  localparam int ADDR_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  // configuration
  logic [rkoc_pkg::CFG_W-1:0] block_length;
  logic [rkoc_pkg::CFG_W-1:0] key_begin;
  logic [rkoc_pkg::CFG_W-1:0] key_end;
  logic                       descending;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length <= rkoc_pkg::CFG_W'(1);
      key_begin    <= '0;
      key_end      <= '0;
      descending   <= 1'b0;
    end else if (cfg_we) begin
      case (rkoc_pkg::cfg_reg_t'(cfg_index))
        rkoc_pkg::REG_BLOCK_LENGTH: block_length <= cfg_data;
        rkoc_pkg::REG_KEY_BEGIN:    key_begin    <= cfg_data;
        rkoc_pkg::REG_KEY_END:      key_end      <= cfg_data;
        rkoc_pkg::REG_DESCENDING:   descending   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input side: position tracking and key store access
  logic [rkoc_pkg::CFG_W-1:0] byte_position;
  logic [rkoc_pkg::CFG_W-1:0] byte_position_next;
  logic [rkoc_pkg::CFG_W-1:0] last_position;
  logic [rkoc_pkg::CFG_W-1:0] key_offset;
  logic                       in_window;
  logic                       key_hit;
  logic                       is_last;
  logic                       in_accept;

  assign last_position = block_length - rkoc_pkg::CFG_W'(1);
  assign in_window     = (byte_position >= key_begin) && (byte_position <= key_end);
  assign key_offset    = byte_position - key_begin;
  assign key_hit       = in_window && ({1'b0, key_offset} < 17'(KEY_BYTES));
  assign is_last       = (byte_position == last_position);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign byte_position_next = is_last ? '0 : byte_position + rkoc_pkg::CFG_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (in_accept) begin
      byte_position <= byte_position_next;
    end
  end

  logic [rkoc_pkg::BYTE_W-1:0] key_mem [KEY_BYTES];
  logic [rkoc_pkg::BYTE_W-1:0] old_byte;

  // read-first: the old byte comes out while the new key byte goes in
  always_ff @(posedge clk) begin
    if (in_accept) begin
      old_byte <= key_mem[key_offset[ADDR_W-1:0]];
      if (key_hit) begin
        key_mem[key_offset[ADDR_W-1:0]] <= s_axis_tdata;
      end
    end
  end

  // compare stage
  logic                        s1_valid;
  logic                        s1_hit;
  logic                        s1_last;
  logic [rkoc_pkg::BYTE_W-1:0] s1_byte;
  logic                        s1_go;
  logic                        out_free;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_go         = s1_valid && (!s1_last || out_free);
  assign s_axis_tready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_hit  <= key_hit;
      s1_last <= is_last;
      s1_byte <= s_axis_tdata;
    end
  end

  rkoc_pkg::cmp_outcome_t      outcome;
  rkoc_pkg::cmp_outcome_t      outcome_next;
  logic                        first_pending;
  logic [rkoc_pkg::INDEX_W-1:0] record_counter;
  logic                        violation_seen;
  logic                        ok;

  always_comb begin
    outcome_next = outcome;
    if (s1_hit && !first_pending && (outcome == rkoc_pkg::CMP_NONE)) begin
      if (s1_byte > old_byte) begin
        outcome_next = rkoc_pkg::CMP_GREATER;
      end else if (s1_byte < old_byte) begin
        outcome_next = rkoc_pkg::CMP_SMALLER;
      end
    end
  end

  assign ok = first_pending ||
              (descending ? (outcome_next != rkoc_pkg::CMP_GREATER)
                          : (outcome_next != rkoc_pkg::CMP_SMALLER));

  always_ff @(posedge clk) begin
    if (rst) begin
      outcome        <= rkoc_pkg::CMP_NONE;
      first_pending  <= 1'b1;
      record_counter <= '0;
      violation_seen <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        outcome       <= rkoc_pkg::CMP_NONE;
        first_pending <= 1'b0;
        violation_seen <= violation_seen || !ok;
        if (record_counter != rkoc_pkg::INDEX_MAX) begin
          record_counter <= record_counter + rkoc_pkg::INDEX_W'(1);
        end
      end else begin
        outcome <= outcome_next;
      end
    end
  end

  // output register
  logic [rkoc_pkg::INDEX_W-1:0] out_index;
  logic                         out_in_order;
  logic                         out_violation;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_go && s1_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      out_index     <= record_counter;
      out_in_order  <= ok;
      out_violation <= violation_seen || !ok;
    end
  end

  assign m_axis_tdata = {6'b0, out_violation, out_in_order, out_index};

endmodule

FILE: hdl/rkoc_checker.sv
// port-level checks for the record key order checker, bound to the top level
module rkoc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rkoc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic                          out_xfer;
  logic                          seen_xfer;
  logic                          seen_violation;
  logic [rkoc_pkg::INDEX_W-1:0]  last_index;

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_xfer      <= 1'b0;
      seen_violation <= 1'b0;
    end else if (out_xfer) begin
      seen_xfer      <= 1'b1;
      seen_violation <= seen_violation || m_axis_tdata[41];
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      last_index <= m_axis_tdata[39:0];
    end
  end

  // a stalled result holds still
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a record out of order always shows in the sticky flag
  assert property (@(posedge clk) disable iff (rst)
    out_xfer && !m_axis_tdata[40] |-> m_axis_tdata[41])
    else $error("violation not flagged");

  // the sticky flag never clears once reported
  assert property (@(posedge clk) disable iff (rst)
    out_xfer && seen_violation |-> m_axis_tdata[41])
    else $error("sticky violation flag dropped");

  // record indexes count up from zero and saturate
  assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (!seen_xfer && m_axis_tdata[39:0] == '0 && m_axis_tdata[40])
              || (seen_xfer && last_index != rkoc_pkg::INDEX_MAX
                  && m_axis_tdata[39:0] == last_index + rkoc_pkg::INDEX_W'(1))
              || (seen_xfer && last_index == rkoc_pkg::INDEX_MAX
                  && m_axis_tdata[39:0] == rkoc_pkg::INDEX_MAX))
    else $error("record index out of sequence");

endmodule

bind record_key_order_checker rkoc_checker u_rkoc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
